// File: hdl/cab_pkg.sv
// Shared constants and types for the CSR adjacency builder.
package cab_pkg;

    localparam int MaxNodes  = 1024;
    localparam int MaxArcs   = 4096;
    localparam int NodeW     = $clog2(MaxNodes);
    localparam int ArcAw     = $clog2(MaxArcs);
    localparam int CntW      = ArcAw + 1;
    localparam int NcW       = 11;
    localparam int PtrW      = CntW + 1;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_OFFSET = 2'd1,
        KIND_ARC    = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PREFIX,
        ST_SCATTER,
        ST_DRAIN,
        ST_CLEAR
    } t_state;

    // One arc as it sits in the sorted store.
    typedef struct packed {
        logic [NodeW-1:0] target;
        logic [31:0]      length_cm;
        logic [7:0]       arc_class;
        logic [63:0]      way;
    } t_arc;

endpackage

// File: hdl/cab_arc_ram.sv
// Simple dual-port arc memory: one write port, one registered read port.
module cab_arc_ram #(
    parameter int Depth = 4096,
    parameter int Width = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

// File: hdl/csr_adjacency_builder.sv
// Top level of the CSR adjacency builder.
//  channel | signals                          | handshake
//  input   | i_start, i_op, arc fields        | taken when i_start && !o_busy
//  result  | o_valid, o_kind..o_last          | one cycle strobe, no stall
//  config  | i_cfg_we, i_cfg_node_count       | if i_cfg_we, no arcs, load/clear
// A load is written at once; o_busy stays high the next cycle while the degree
// count is updated, so a new load waits until that update is done. The first read
// request runs the prefix pass (min(node_count, MaxNodes)+1 entries) and the
// scatter pass over the stored arcs, then the header word strobes. Each later
// read request sets r_req, from which the word is registered onto the outputs;
// the next request can be taken while that word is shown. After the last word
// and after reset a clearing pass over all MaxNodes entries zeroes the degree
// memory; o_busy is high throughout.
module csr_adjacency_builder (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    output logic                       o_busy,
    input  logic                       i_cfg_we,
    input  logic [10:0]                i_cfg_node_count,
    input  logic                       i_op,
    input  logic [9:0]                 i_source_node,
    input  logic [9:0]                 i_target_node,
    input  logic [31:0]                i_arc_length_cm,
    input  logic [7:0]                 i_arc_class,
    input  logic signed [63:0]         i_arc_way,
    output logic                       o_valid,
    output logic [1:0]                 o_kind,
    output logic [12:0]                o_position,
    output logic [12:0]                o_offset_value,
    output logic [12:0]                o_stored_arcs,
    output logic [9:0]                 o_out_target,
    output logic [31:0]                o_out_length_cm,
    output logic [7:0]                 o_out_class,
    output logic signed [63:0]         o_out_way,
    output logic                       o_dropped_flag,
    output logic                       o_last
);
    import cab_pkg::*;

    localparam int LoadW = NodeW + $bits(t_arc);

    t_state r_state, n_state;

    logic [NcW-1:0]   r_node_count;
    logic [CntW-1:0]  r_total;
    logic             r_drop;
    logic [PtrW-1:0]  r_ptr;       // drain word / prefix index / scatter index
    logic [CntW-1:0]  r_acc;       // running prefix sum
    logic             r_phase;     // phase toggle within each prefix/scatter step
    logic             r_req;       // drain request pending read
    logic [NodeW:0]   r_clr;
    // load increments go through a pending register (read then write)
    logic             r_inc;
    logic [NodeW-1:0] r_inc_addr;

    logic [NcW-1:0]   w_n;
    assign w_n = (r_node_count > NcW'(MaxNodes)) ? NcW'(MaxNodes) : r_node_count;

    // degree / cursor memory
    logic [CntW-1:0]  deg_mem [MaxNodes];
    logic [NodeW-1:0] deg_raddr;
    logic [CntW-1:0]  deg_rdata;
    logic             deg_we;
    logic [NodeW-1:0] deg_waddr;
    logic [CntW-1:0]  deg_wdata;

    // offset memory
    logic [CntW-1:0]  off_mem [MaxNodes+1];
    logic [NodeW:0]   off_raddr;
    logic [CntW-1:0]  off_rdata;
    logic             off_we;
    logic [NodeW:0]   off_waddr;

    always_ff @(posedge i_clk) begin
        if (deg_we) deg_mem[deg_waddr] <= deg_wdata;
        deg_rdata <= deg_mem[deg_raddr];
        if (off_we) off_mem[off_waddr] <= r_acc;
        off_rdata <= off_mem[off_raddr];
    end

    // arc stores
    logic              ld_we;
    logic [LoadW-1:0]  ld_wdata, ld_rdata;
    logic [ArcAw-1:0]  ld_raddr;
    logic              so_we;
    logic [ArcAw-1:0]  so_waddr, so_raddr;
    t_arc              so_rdata, ld_arc;
    logic [NodeW-1:0]  ld_src;

    assign ld_wdata = {i_source_node, i_target_node, i_arc_length_cm, i_arc_class,
                       i_arc_way};
    assign ld_src   = ld_rdata[LoadW-1 -: NodeW];
    assign ld_arc   = t_arc'(ld_rdata[$bits(t_arc)-1:0]);

    cab_arc_ram #(.Depth(MaxArcs), .Width(LoadW)) u_loaded (
        .i_clk(i_clk), .i_we(ld_we), .i_waddr(r_total[ArcAw-1:0]),
        .i_wdata(ld_wdata), .i_raddr(ld_raddr), .o_rdata(ld_rdata));

    cab_arc_ram #(.Depth(MaxArcs), .Width($bits(t_arc))) u_sorted (
        .i_clk(i_clk), .i_we(so_we), .i_waddr(so_waddr),
        .i_wdata(ld_arc), .i_raddr(so_raddr), .o_rdata(so_rdata));

    logic w_take, w_load_ok;
    assign w_take    = i_start && !o_busy;
    assign w_load_ok = w_take && (r_state == ST_LOAD) && !i_op
                       && (r_total < CntW'(MaxArcs)) && (NcW'(i_source_node) < w_n);

    // drain bookkeeping
    logic [PtrW-1:0] w_total_words;
    logic [PtrW-1:0] w_slot_raw;
    logic [ArcAw-1:0] w_slot;
    logic            w_in_off;
    assign w_total_words = PtrW'(w_n) + PtrW'(2) + PtrW'(r_total);
    assign w_in_off      = (r_ptr != '0) && (r_ptr <= PtrW'(w_n) + PtrW'(1));
    assign w_slot_raw    = r_ptr - PtrW'(w_n) - PtrW'(2);
    assign w_slot        = (w_slot_raw >= PtrW'(MaxArcs)) ? ArcAw'(MaxArcs - 1)
                                                          : w_slot_raw[ArcAw-1:0];
    logic [PtrW-1:0] w_oidx;
    assign w_oidx = r_ptr - PtrW'(1);

    logic w_pre_done, w_sc_done, w_last_word;
    assign w_pre_done  = r_phase && (r_ptr[NodeW:0] == w_n[NodeW:0]);
    assign w_sc_done   = (r_ptr == PtrW'(r_total));
    assign w_last_word = (r_ptr + PtrW'(1) >= w_total_words);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD:    if (w_take && i_op) n_state = ST_PREFIX;
            ST_PREFIX:  if (w_pre_done) n_state = ST_SCATTER;
            ST_SCATTER: if (w_sc_done) n_state = ST_DRAIN;
            ST_DRAIN:   if (r_req && w_last_word) n_state = ST_CLEAR;
            ST_CLEAR:   if (r_clr == (NodeW+1)'(MaxNodes - 1)) n_state = ST_LOAD;
            default:    n_state = ST_LOAD;
        endcase
    end

    // memory control
    always_comb begin
        deg_raddr = i_source_node;
        deg_we    = 1'b0;
        deg_waddr = i_source_node;
        deg_wdata = deg_rdata;
        off_raddr = w_oidx[NodeW:0];
        off_we    = 1'b0;
        off_waddr = r_ptr[NodeW:0];
        ld_we     = 1'b0;
        ld_raddr  = r_ptr[ArcAw-1:0];
        so_we     = 1'b0;
        so_waddr  = deg_rdata[ArcAw-1:0];
        so_raddr  = w_slot;
        unique case (r_state)
            ST_LOAD: begin
                ld_we = w_load_ok;
                // degree read issued at the load edge, written back while r_inc is set
                if (r_inc) begin
                    deg_we    = 1'b1;
                    deg_waddr = r_inc_addr;
                    deg_wdata = deg_rdata + CntW'(1);
                end
            end
            ST_PREFIX: begin
                deg_raddr = r_ptr[NodeW-1:0];
                // first arc is ready when the scatter pass starts
                ld_raddr  = '0;
                if (!r_phase) begin
                    off_we = 1'b1;
                end else if (r_ptr[NodeW:0] != w_n[NodeW:0]) begin
                    deg_we    = 1'b1;
                    deg_waddr = r_ptr[NodeW-1:0];
                    deg_wdata = r_acc;
                end
            end
            ST_SCATTER: begin
                deg_raddr = ld_src;
                if (r_phase) begin
                    ld_raddr  = r_ptr[ArcAw-1:0] + ArcAw'(1);
                    deg_we    = 1'b1;
                    deg_waddr = ld_src;
                    deg_wdata = deg_rdata + CntW'(1);
                    so_we     = (deg_rdata < CntW'(MaxArcs));
                end
            end
            ST_DRAIN: ;
            ST_CLEAR: begin
                deg_we    = 1'b1;
                deg_waddr = r_clr[NodeW-1:0];
                deg_wdata = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_node_count <= NcW'(MaxNodes);
            r_total      <= '0;
            r_drop       <= 1'b0;
            r_ptr        <= '0;
            r_acc        <= '0;
            r_phase      <= 1'b0;
            r_req        <= 1'b0;
            r_clr        <= '0;
            r_inc        <= 1'b0;
            o_valid      <= 1'b0;
        end else begin
            r_state <= n_state;
            o_valid <= (r_state == ST_DRAIN) && r_req;
            r_inc   <= w_load_ok;
            if (i_cfg_we && r_total == '0 && (r_state == ST_LOAD || r_state == ST_CLEAR))
                r_node_count <= i_cfg_node_count;
            unique case (r_state)
                ST_LOAD: begin
                    if (w_load_ok) begin
                        r_total    <= r_total + CntW'(1);
                        r_inc_addr <= i_source_node;
                    end else if (w_take && !i_op) begin
                        r_drop <= 1'b1;
                    end
                    if (w_take && i_op) begin
                        r_ptr   <= '0;
                        r_acc   <= '0;
                        r_phase <= 1'b0;
                    end
                end
                ST_PREFIX: begin
                    r_phase <= !r_phase;
                    if (r_phase) begin
                        r_acc <= r_acc + deg_rdata;
                        if (w_pre_done) r_ptr <= '0;
                        else r_ptr <= r_ptr + PtrW'(1);
                    end
                end
                ST_SCATTER: begin
                    if (w_sc_done) begin
                        r_ptr   <= '0;
                        r_req   <= 1'b1;
                        r_phase <= 1'b0;
                    end else begin
                        r_phase <= !r_phase;
                        if (r_phase) r_ptr <= r_ptr + PtrW'(1);
                    end
                end
                ST_DRAIN: begin
                    if (r_req) begin
                        r_req          <= 1'b0;
                        o_dropped_flag <= r_drop;
                        o_last         <= w_last_word;
                        if (r_ptr == '0) begin
                            o_kind          <= KIND_HEADER;
                            o_position      <= '0;
                            o_offset_value  <= '0;
                            o_stored_arcs   <= 13'(r_total);
                            o_out_target    <= '0;
                            o_out_length_cm <= '0;
                            o_out_class     <= '0;
                            o_out_way       <= '0;
                        end else if (w_in_off) begin
                            o_kind          <= KIND_OFFSET;
                            o_position      <= 13'(w_oidx);
                            o_offset_value  <= 13'(off_rdata);
                            o_stored_arcs   <= '0;
                            o_out_target    <= '0;
                            o_out_length_cm <= '0;
                            o_out_class     <= '0;
                            o_out_way       <= '0;
                        end else begin
                            o_kind          <= KIND_ARC;
                            o_position      <= 13'(w_slot);
                            o_offset_value  <= '0;
                            o_stored_arcs   <= '0;
                            o_out_target    <= so_rdata.target;
                            o_out_length_cm <= so_rdata.length_cm;
                            o_out_class     <= so_rdata.arc_class;
                            o_out_way       <= so_rdata.way;
                        end
                        if (w_last_word) begin
                            r_total <= '0;
                            r_drop  <= 1'b0;
                            r_clr   <= '0;
                        end else begin
                            r_ptr <= r_ptr + PtrW'(1);
                        end
                    end else if (w_take && i_op) begin
                        r_req <= 1'b1;
                    end
                end
                ST_CLEAR: r_clr <= r_clr + (NodeW+1)'(1);
                default: ;
            endcase
        end
    end

    // busy outside load and idle drain, and while a load increment completes
    assign o_busy = ((r_state != ST_LOAD) && !(r_state == ST_DRAIN && !r_req)) || r_inc;

    a_valid_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid);
    a_total_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CntW'(MaxArcs));
    a_kind_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_kind == KIND_HEADER || o_kind == KIND_OFFSET || o_kind == KIND_ARC));
    a_busy_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_LOAD && r_state != ST_DRAIN) |-> o_busy);

endmodule

// File: verif/tb_csr_adjacency_builder.sv
// Testbench for the CSR adjacency builder: arc loads, read runs and scoreboard.
`timescale 1ns / 100ps

module tb_csr_adjacency_builder;
    import cab_pkg::*;

    localparam int CycleLimit = 500000;
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic        op;
        logic [9:0]  src;
        logic [9:0]  dst;
        logic [31:0] len;
        logic [7:0]  cls;
        logic [63:0] way;
    } t_cmd;

    typedef struct packed {
        t_kind       kind;
        logic [12:0] position;
        logic [12:0] offset_value;
        logic [12:0] stored;
        logic [9:0]  target;
        logic [31:0] length_cm;
        logic [7:0]  arc_class;
        logic [63:0] way;
        logic        dropped;
        logic        last;
    } t_word;

    logic i_clk, i_rst_n, i_start, o_busy, i_cfg_we;
    logic [10:0] i_cfg_node_count;
    logic i_op;
    logic [9:0] i_source_node, i_target_node;
    logic [31:0] i_arc_length_cm;
    logic [7:0] i_arc_class;
    logic signed [63:0] i_arc_way;
    logic o_valid;
    logic [1:0] o_kind;
    logic [12:0] o_position, o_offset_value, o_stored_arcs;
    logic [9:0] o_out_target;
    logic [31:0] o_out_length_cm;
    logic [7:0] o_out_class;
    logic signed [63:0] o_out_way;
    logic o_dropped_flag, o_last;

    csr_adjacency_builder i_dut (.*);

    // predictor state
    int unsigned       nodes_reg;
    int unsigned       degree [MaxNodes];
    int unsigned       row_start [MaxNodes+1];
    t_cmd              arc_log [MaxArcs];
    t_arc              row_arcs [MaxArcs];
    int unsigned       arcs_held;
    int unsigned       read_ptr;
    bit                draining;
    bit                drop_hit;

    t_cmd  pending_cmds[$];
    t_word expected_words[$];
    bit    failed;
    int    cycle_cnt;
    int    idle_pct;
    int    queued_items;
    logic  o_busy_q;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned active_nodes();
        return nodes_reg > MaxNodes ? MaxNodes : nodes_reg;
    endfunction

    function automatic void clear_graph();
        foreach (degree[i]) degree[i] = 0;
        arcs_held = 0;
        read_ptr = 0;
        draining = 0;
        drop_hit = 0;
    endfunction

    function automatic void queue_cmd(t_cmd c);
        pending_cmds = {pending_cmds, c};
        queued_items++;
    endfunction

    function automatic void sort_rows();
        int unsigned n, s, p;
        n = active_nodes();
        row_start[0] = 0;
        for (int unsigned i = 0; i < n; i++) begin
            row_start[i+1] = row_start[i] + degree[i];
            degree[i] = row_start[i];
        end
        for (int unsigned i = 0; i < arcs_held; i++) begin
            s = arc_log[i].src;
            if (s >= n) continue;
            p = degree[s];
            degree[s] = p + 1;
            if (p >= MaxArcs) continue;
            row_arcs[p] = '{arc_log[i].dst, arc_log[i].len, arc_log[i].cls, arc_log[i].way};
        end
    endfunction

    function automatic void predict_word(t_cmd c);
        int unsigned n, total, slot;
        t_word w;
        n = active_nodes();
        if (c.op == OP_LOAD) begin
            if (draining) return;
            if (arcs_held >= MaxArcs || c.src >= n) begin
                drop_hit = 1;
                return;
            end
            arc_log[arcs_held] = c;
            degree[c.src]++;
            arcs_held++;
            return;
        end
        if (!draining) begin
            sort_rows();
            draining = 1;
            read_ptr = 0;
        end
        w = '0;
        w.dropped = drop_hit;
        total = 1 + n + 1 + arcs_held;
        if (read_ptr == 0) begin
            w.kind = KIND_HEADER;
            w.stored = arcs_held[12:0];
        end else if (read_ptr <= n + 1) begin
            w.kind = KIND_OFFSET;
            w.position = 13'(read_ptr - 1);
            w.offset_value = row_start[read_ptr-1][12:0];
        end else begin
            slot = read_ptr - n - 2;
            if (slot >= MaxArcs) slot = MaxArcs - 1;
            w.kind = KIND_ARC;
            w.position = slot[12:0];
            w.target = row_arcs[slot].target;
            w.length_cm = row_arcs[slot].length_cm;
            w.arc_class = row_arcs[slot].arc_class;
            w.way = row_arcs[slot].way;
        end
        if (read_ptr + 1 >= total) begin
            w.last = 1;
            clear_graph();
        end else begin
            read_ptr++;
        end
        expected_words = {expected_words, w};
    endfunction

    function automatic t_cmd rand_arc(int unsigned n);
        t_cmd c;
        c.op = OP_LOAD;
        c.src = ($urandom_range(0, 19) == 0) ? 10'($urandom) : 10'($urandom_range(0, n - 1));
        c.dst = 10'($urandom);
        c.len = $urandom;
        c.cls = 8'($urandom);
        c.way = {$urandom, $urandom};
        return c;
    endfunction

    function automatic t_cmd read_cmd();
        t_cmd c;
        c = '0;
        c.op = OP_READ;
        c.src = 10'($urandom);
        return c;
    endfunction

    always @(posedge i_clk) o_busy_q <= o_busy;

    task automatic drive_next();
        t_cmd c;
        if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
            c = pending_cmds[0];
            i_start <= 1;
            i_op <= c.op;
            i_source_node <= c.src;
            i_target_node <= c.dst;
            i_arc_length_cm <= c.len;
            i_arc_class <= c.cls;
            i_arc_way <= c.way;
        end else begin
            i_start <= 0;
        end
    endtask

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 0;
        end else if (i_start && !o_busy_q) begin
            // previous word taken at the last rising edge
            void'(pending_cmds.pop_front());
            drive_next();
        end else if (!i_start) begin
            drive_next();
        end
    end

    // predict on acceptance
    always @(posedge i_clk) begin
        if (i_rst_n && i_start && !o_busy)
            predict_word(pending_cmds[0]);
    end

    // monitor
    always @(posedge i_clk) begin
        t_word e;
        if (i_rst_n && o_valid) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word kind %0d pos %0d", $time, o_kind, o_position);
                failed = 1;
            end else begin
                e = expected_words.pop_front();
                if (o_kind !== e.kind || o_position !== e.position
                    || o_offset_value !== e.offset_value || o_stored_arcs !== e.stored
                    || o_out_target !== e.target || o_out_length_cm !== e.length_cm
                    || o_out_class !== e.arc_class || o_out_way !== e.way
                    || o_dropped_flag !== e.dropped || o_last !== e.last) begin
                    $display("%0t: mismatch expected %h actual %h", $time, e,
                             {o_kind, o_position, o_offset_value, o_stored_arcs, o_out_target,
                              o_out_length_cm, o_out_class, o_out_way, o_dropped_flag, o_last});
                    failed = 1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CycleLimit) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || i_start || expected_words.size() != 0)
            @(posedge i_clk);
        repeat (MaxNodes + 20) @(posedge i_clk);
    endtask

    // write node count while idle, then a full graph: arcs then a full read run
    task automatic run_graph(int unsigned nc, int unsigned arcs, bit with_noise);
        t_cmd c;
        int unsigned n, words, kept;
        wait_drained();
        @(negedge i_clk);
        i_cfg_node_count <= 11'(nc);
        i_cfg_we <= 1;
        @(negedge i_clk);
        i_cfg_we <= 0;
        if (arcs_held == 0 && !draining)
            nodes_reg = nc;
        n = active_nodes();
        kept = 0;
        for (int i = 0; i < arcs; i++) begin
            if (n == 0) begin
                c = rand_arc(1);
            end else begin
                c = rand_arc(n);
            end
            if (c.src < n && kept < MaxArcs)
                kept++;
            queue_cmd(c);
        end
        words = 2 + n + kept;
        for (int i = 0; i < words; i++) begin
            // some loads mixed into the drain are ignored
            if (with_noise && $urandom_range(0, 9) == 0 && i > 0)
                queue_cmd(rand_arc(n == 0 ? 1 : n));
            queue_cmd(read_cmd());
        end
    endtask

    initial begin
        t_cmd c;
        failed = 0;
        cycle_cnt = 0;
        queued_items = 0;
        idle_pct = 38;
        i_rst_n = 0;
        i_start = 0;
        i_cfg_we = 0;
        i_cfg_node_count = 0;
        i_op = 0;
        i_source_node = 0;
        i_target_node = 0;
        i_arc_length_cm = 0;
        i_arc_class = 0;
        i_arc_way = 0;
        nodes_reg = 1024;
        clear_graph();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed: extremes of fields at the reset node count
        c = '{OP_LOAD, 10'h3FF, 10'h3FF, 32'hFFFF_FFFF, 8'hFF, 64'h8000_0000_0000_0000};
        queue_cmd(c);
        c = '{OP_LOAD, 10'h000, 10'h000, 32'h0, 8'h00, 64'h7FFF_FFFF_FFFF_FFFF};
        queue_cmd(c);
        c = '{OP_LOAD, 10'h3FF, 10'h155, 32'h5555_AAAA, 8'hA5, 64'hFFFF_FFFF_FFFF_FFFF};
        queue_cmd(c);
        for (int i = 0; i < 1024 + 5; i++) queue_cmd(read_cmd());
        // a stretch of the read run with no idling
        while (pending_cmds.size() >= 600) @(posedge i_clk);
        idle_pct = 0;
        while (pending_cmds.size() >= 350) @(posedge i_clk);
        idle_pct = 38;
        // node count 2: any bad sources dropped, stable order within a row
        run_graph(2, 6, 0);
        // zero nodes: everything dropped, offsets are a single entry
        run_graph(0, 3, 0);
        // empty graph at node count 1
        run_graph(1, 0, 0);

        // random small graphs
        while (queued_items < 1150) begin
            int unsigned nc, na;
            nc = $urandom_range(0, 16);
            na = $urandom_range(0, 12);
            run_graph(nc, na, 1);
        end

        wait_drained();
        if (!failed) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/cab_pkg.sv
hdl/cab_arc_ram.sv
hdl/csr_adjacency_builder.sv
verif/tb_csr_adjacency_builder.sv
